// ===== hw/rtl/htfp_pkg.sv =====
// Shared constants, types and the FNV-1a byte step for the head/tail fingerprint unit.
`timescale 1ns / 1ps

package htfp_pkg;

   // Field and register widths
   localparam int unsigned LEN_W  = 40;
   localparam int unsigned TIME_W = 34;
   localparam int unsigned HASH_W = 64;
   localparam int unsigned BYTE_W = 8;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic        CSR_SEL_LENGTH = 1'b0;  // byte address 0
   localparam logic        CSR_SEL_TIME   = 1'b1;  // byte address 8

   // Size of the head window and of the tail window in bytes
   localparam int unsigned CHUNK_BYTES = 4096;

   // FNV-1a 64 constants; the prime is 2^40 + 0x1b3
   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   // Finalization folds the eight bytes of the combined hash
   localparam int unsigned FIN_STEPS = HASH_W / BYTE_W;
   localparam int unsigned FIN_CNT_W = $clog2(FIN_STEPS);

   localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic absorb;     // take the current request byte
      logic fin_step;   // fold one byte of the combined hash
      logic load_out;   // move the finished hash into the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic last_byte;  // the byte at the current index closes the archive
   } sts_type;

   // One FNV-1a step: xor in the byte, multiply by the prime as shift-add
   function automatic logic [HASH_W-1:0] fnv_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ===== hw/rtl/htfp_ctrl.sv =====
// Controller: sequences absorb, finalization and result delivery.
`timescale 1ns / 1ps

module htfp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  htfp_pkg::sts_type sts,
   output htfp_pkg::cmd_type cmd
);
   import htfp_pkg::*;

   typedef enum logic [1:0] {
      ST_ABSORB,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [FIN_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Accept bytes only while absorbing; the result register sits apart
   assign req_stall = (state_ff != ST_ABSORB);
   assign rsp_valid = rsp_valid_ff;

   // Issue datapath commands
   always_comb begin
      cmd.absorb   = (state_ff == ST_ABSORB) && req_valid;
      cmd.fin_step = (state_ff == ST_FINISH);
      cmd.load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state, step count and result valid
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_ABSORB: begin
            if (req_valid && sts.last_byte) begin
               state_in = ST_FINISH;
               cnt_in   = '0;
            end
         end
         ST_FINISH: begin
            cnt_in = cnt_ff + FIN_CNT_W'(1);
            if (cnt_ff == FIN_CNT_W'(FIN_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (cmd.load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_ABSORB;
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ABSORB;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/htfp_datapath.sv =====
// Datapath: byte index, head and tail hashes, finalizer and result register.
`timescale 1ns / 1ps

module htfp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  htfp_pkg::cmd_type             cmd,
   output htfp_pkg::sts_type             sts,
   input  logic [htfp_pkg::BYTE_W-1:0]   data_byte,
   input  logic [htfp_pkg::LEN_W-1:0]    archive_length,
   input  logic [htfp_pkg::TIME_W-1:0]   modification_time,
   output logic [htfp_pkg::HASH_W-1:0]   fingerprint_hash,
   output logic [htfp_pkg::LEN_W-1:0]    total_length,
   output logic [htfp_pkg::TIME_W-1:0]   stamp_time
);
   import htfp_pkg::*;

   logic [LEN_W-1:0]  index_ff;
   logic [HASH_W-1:0] head_ff, tail_ff;
   logic [HASH_W-1:0] comb_ff, fin_ff;
   logic [LEN_W-1:0]  fin_len_ff;
   logic [TIME_W-1:0] fin_time_ff;
   logic [HASH_W-1:0] out_hash_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic [TIME_W-1:0] out_time_ff;

   logic [LEN_W-1:0]  len_m1;
   logic [LEN_W-1:0]  tail_start;
   logic              long_archive;
   logic              in_head, in_tail;
   logic [HASH_W-1:0] head_in, tail_in;

   // Length zero means 2^40 bytes; the wrapped minus-one covers it
   assign len_m1       = archive_length - LEN_W'(1);
   assign long_archive = (archive_length == '0) || (archive_length > LEN_W'(CHUNK_BYTES));
   assign tail_start   = len_m1 - LEN_W'(CHUNK_BYTES - 1);

   // Window membership of the current byte
   assign in_head = (index_ff < LEN_W'(CHUNK_BYTES));
   assign in_tail = long_archive && (index_ff >= tail_start);
   assign sts.last_byte = (index_ff >= len_m1);

   assign head_in = in_head ? fnv_byte(head_ff, data_byte) : head_ff;
   assign tail_in = in_tail ? fnv_byte(tail_ff, data_byte) : tail_ff;

   // Advance the running state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         head_ff  <= FNV_BASIS;
         tail_ff  <= FNV_BASIS;
      end else if (cmd.absorb) begin
         if (sts.last_byte) begin
            index_ff <= '0;
            head_ff  <= FNV_BASIS;
            tail_ff  <= FNV_BASIS;
         end else begin
            index_ff <= index_ff + LEN_W'(1);
            head_ff  <= head_in;
            tail_ff  <= tail_in;
         end
      end
   end

   // Capture the combined hash, then fold it one byte per cycle
   always_ff @(posedge clock) begin
      if (cmd.absorb && sts.last_byte) begin
         comb_ff     <= head_in ^ (long_archive ? tail_in : '0);
         fin_ff      <= FNV_BASIS;
         fin_len_ff  <= archive_length;
         fin_time_ff <= modification_time;
      end else if (cmd.fin_step) begin
         fin_ff  <= fnv_byte(fin_ff, comb_ff[BYTE_W-1:0]);
         comb_ff <= comb_ff >> BYTE_W;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_hash_ff <= fin_ff;
         out_len_ff  <= fin_len_ff;
         out_time_ff <= fin_time_ff;
      end
   end

   assign fingerprint_hash = out_hash_ff;
   assign total_length     = out_len_ff;
   assign stamp_time       = out_time_ff;

endmodule

// ===== hw/rtl/head_tail_fnv1a_fingerprint_unit.sv =====
// Top level of the head/tail FNV-1a 64 fingerprint unit with its register port.
//
// Usage: program archive_length (byte address 0) and modification_time
// (byte address 8) over the csr_ port, then stream the archive one byte per
// request on req_. The unit hashes the first 4096 bytes and, for longer
// archives, the last 4096 bytes, XORs the two, folds the result through
// FNV-1a once more and returns one rsp_ item after the last byte.
// Throughput: one byte per cycle while absorbing. After the last byte the
// finalizer folds in each byte of the combined hash, then loads the result
// register once it is free, which raises rsp_valid; req_stall is high from
// the last byte until the result register is loaded.
// The result register lets the next archive stream in while a result waits.
// If a result is still stalled when the next one finishes, the unit holds
// req_stall high until rsp_stall drops.
// Reset (synchronous, active high) clears the byte index and hashes and sets
// archive_length to 1 and modification_time to 0; no result is pending.
`timescale 1ns / 1ps

module head_tail_fnv1a_fingerprint_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [htfp_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [htfp_pkg::HASH_W-1:0]       rsp_fingerprint_hash,
   output logic [htfp_pkg::LEN_W-1:0]        rsp_total_length,
   output logic [htfp_pkg::TIME_W-1:0]       rsp_stamp_time,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [htfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [htfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [htfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import htfp_pkg::*;

   logic [LEN_W-1:0]  length_ff;
   logic [TIME_W-1:0] mtime_ff;
   logic              csr_wr;
   cmd_type           cmd;
   sts_type           sts;

   // Register write on the access phase; bit 3 selects the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= RESET_LENGTH;
         mtime_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3] == CSR_SEL_LENGTH) begin
            length_ff <= csr_pwdata[LEN_W-1:0];
         end else begin
            mtime_ff <= csr_pwdata[TIME_W-1:0];
         end
      end
   end

   // Read back the selected register
   always_comb begin
      if (csr_paddr[3] == CSR_SEL_TIME) begin
         csr_prdata = {{(CSR_DATA_W-TIME_W){1'b0}}, mtime_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, length_ff};
      end
   end

   htfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   htfp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .data_byte         (req_data_byte),
      .archive_length    (length_ff),
      .modification_time (mtime_ff),
      .fingerprint_hash  (rsp_fingerprint_hash),
      .total_length      (rsp_total_length),
      .stamp_time        (rsp_stamp_time)
   );

endmodule

// ===== hw/rtl/htfp_checker.sv =====
// Port-level checker for the fingerprint unit, bound to the top level.
`timescale 1ns / 1ps

module htfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [htfp_pkg::BYTE_W-1:0]       req_data_byte,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [htfp_pkg::HASH_W-1:0]       rsp_fingerprint_hash,
   input logic [htfp_pkg::LEN_W-1:0]        rsp_total_length,
   input logic [htfp_pkg::TIME_W-1:0]       rsp_stamp_time,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [htfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [htfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [htfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_fingerprint_hash))
      else $error("stalled result hash changed");

   // Reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result appears only after the finalizer has held off requests
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while requests were open");

endmodule

bind head_tail_fnv1a_fingerprint_unit htfp_checker u_htfp_checker (.*);
